[rtl/igbs_pkg.sv]
// ----------------------------------------------------------------------
// IMU gyro bias and scale: shared package
// Codes, constants, command and status bundles shared by the controller
// and the datapath.
// ----------------------------------------------------------------------
package igbs_pkg;

  // Action codes carried in the input tuser.
  localparam logic [1:0] ACT_CONVERT = 2'd0;
  localparam logic [1:0] ACT_CAL     = 2'd1;
  localparam logic [1:0] ACT_ABORT   = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CAL_DONE = 2'd1;
  localparam logic [1:0] ST_ERR_ZERO = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ACCEL_RANGE = 2'd0;
  localparam logic [1:0] CFG_GYRO_RANGE  = 2'd1;
  localparam logic [1:0] CFG_CAL_COUNT   = 2'd2;

  // Configuration reset values.
  localparam logic [1:0]  ACCEL_RANGE_RST = 2'd3;
  localparam logic [1:0]  GYRO_RANGE_RST  = 2'd3;
  localparam logic [15:0] CAL_COUNT_RST   = 16'd1000;

  // Multiplier and divider unit selects.
  localparam logic [1:0] AXIS_X   = 2'd0;
  localparam logic [1:0] AXIS_Y   = 2'd1;
  localparam logic [1:0] AXIS_Z   = 2'd2;
  localparam logic [1:0] MUL_TEMP = 2'd3;

  // Dividend is |sum| * 16, at most 35 bits; one quotient bit per cycle.
  localparam int unsigned DIV_W     = 36;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W);

  localparam logic signed [17:0] TEMP_SCALE  = 18'sd50251;
  localparam logic signed [15:0] TEMP_OFFSET = 16'sd5376;

  // Gyro scale factor per range code, in 2^-16 units of 1/16 dps.
  function automatic logic signed [17:0] gyro_k(input logic [1:0] range_code);
    logic signed [17:0] k;
    case (range_code)
      2'd0:    k = 18'sd500;
      2'd1:    k = 18'sd1001;
      2'd2:    k = 18'sd1998;
      default: k = 18'sd3996;
    endcase
    return k;
  endfunction

  typedef struct packed {
    logic       load;
    logic       accum;
    logic       abort;
    logic       err;
    logic       mul;
    logic       wb;
    logic [1:0] sel;
    logic       div_init;
    logic       div_step;
    logic       div_store;
    logic       cal_done;
    logic       out_load;
  } igbs_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       cnt_zero;
    logic       cal_full;
    logic       out_free;
  } igbs_stat_t;

endpackage

[rtl/igbs_ctrl.sv]
// ----------------------------------------------------------------------
// IMU gyro bias and scale: controller
// Sequences one request through conversion, accumulation or the bias
// division, and hands the result to the output register.
// ----------------------------------------------------------------------
module igbs_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  igbs_pkg::igbs_stat_t  stat,
  output igbs_pkg::igbs_cmd_t   cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DISPATCH  = 4'd1;
  localparam logic [3:0] S_MUL       = 4'd2;
  localparam logic [3:0] S_WB        = 4'd3;
  localparam logic [3:0] S_CHECK     = 4'd4;
  localparam logic [3:0] S_DIV_INIT  = 4'd5;
  localparam logic [3:0] S_DIV_STEP  = 4'd6;
  localparam logic [3:0] S_DIV_STORE = 4'd7;
  localparam logic [3:0] S_CAL_DONE  = 4'd8;
  localparam logic [3:0] S_DONE      = 4'd9;

  localparam logic [igbs_pkg::DIV_CNT_W-1:0] DIV_LAST =
    igbs_pkg::DIV_CNT_W'(igbs_pkg::DIV_W - 1);

  logic [3:0]                       state_r, state_nxt;
  logic [1:0]                       sel_r, sel_nxt;
  logic [igbs_pkg::DIV_CNT_W-1:0]   bit_r, bit_nxt;

  always_comb begin
    cmd       = '0;
    cmd.sel   = sel_r;
    state_nxt = state_r;
    sel_nxt   = sel_r;
    bit_nxt   = bit_r;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.action)
          igbs_pkg::ACT_CONVERT: begin
            sel_nxt   = igbs_pkg::AXIS_X;
            state_nxt = S_MUL;
          end
          igbs_pkg::ACT_CAL: begin
            if (stat.cnt_zero) begin
              cmd.err   = 1'b1;
              state_nxt = S_DONE;
            end else begin
              cmd.accum = 1'b1;
              state_nxt = S_CHECK;
            end
          end
          igbs_pkg::ACT_ABORT: begin
            cmd.abort = 1'b1;
            state_nxt = S_DONE;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_WB;
      end
      S_WB: begin
        cmd.wb = 1'b1;
        if (sel_r == igbs_pkg::MUL_TEMP) begin
          state_nxt = S_DONE;
        end else begin
          sel_nxt   = sel_r + 2'd1;
          state_nxt = S_MUL;
        end
      end
      S_CHECK: begin
        if (stat.cal_full) begin
          sel_nxt   = igbs_pkg::AXIS_X;
          state_nxt = S_DIV_INIT;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        bit_nxt      = '0;
        state_nxt    = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        cmd.div_step = 1'b1;
        if (bit_r == DIV_LAST) begin
          state_nxt = S_DIV_STORE;
        end else begin
          bit_nxt = bit_r + 1'b1;
        end
      end
      S_DIV_STORE: begin
        cmd.div_store = 1'b1;
        if (sel_r == igbs_pkg::AXIS_Z) begin
          state_nxt = S_CAL_DONE;
        end else begin
          sel_nxt   = sel_r + 2'd1;
          state_nxt = S_DIV_INIT;
        end
      end
      S_CAL_DONE: begin
        cmd.cal_done = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        // Wait here only while the previous result is still unclaimed.
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= igbs_pkg::AXIS_X;
      bit_r   <= '0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      bit_r   <= bit_nxt;
    end
  end

endmodule

[rtl/igbs_datapath.sv]
// ----------------------------------------------------------------------
// IMU gyro bias and scale: datapath
// Configuration and calibration state, shared multiplier, bit-serial bias
// divider and the output register.
// ----------------------------------------------------------------------
module igbs_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  igbs_pkg::igbs_cmd_t   cmd,
  output igbs_pkg::igbs_stat_t  stat,
  input  logic [111:0]          in_tdata,
  input  logic [1:0]            in_tuser,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_addr,
  input  logic [15:0]           cfg_wdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [127:0]          out_tdata,
  output logic [2:0]            out_tuser
);

  // Configuration.
  logic [1:0]  accel_range_r;
  logic [1:0]  gyro_range_r;
  logic [15:0] cal_count_r;

  // Latched request.
  logic [1:0]         act_r;
  logic signed [15:0] a_raw_r [3];
  logic signed [15:0] g_raw_r [3];
  logic signed [15:0] temp_raw_r;

  // Calibration state.
  logic signed [32:0] sum_r  [3];
  logic signed [19:0] bias_r [3];
  logic [15:0]        taken_r;
  logic               calibrated_r;

  // Conversion results.
  logic signed [38:0] prod_r;
  logic signed [16:0] gyro_res_r [3];
  logic signed [15:0] temp_res_r;
  logic [1:0]         status_r;

  // Divider.
  logic [15:0]                 rem_r;
  logic [igbs_pkg::DIV_W-1:0]  quo_r;
  logic                        neg_r;

  // Output register.
  logic         out_valid_r;
  logic [127:0] out_data_r;
  logic [2:0]   out_user_r;

  logic signed [20:0] gyro_x16;
  logic signed [20:0] bias_ext;
  logic signed [20:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [38:0] prod;
  logic signed [38:0] prod_sh;
  logic signed [32:0] sum_sel;
  logic [32:0]        mag;
  logic [16:0]        rem_sh;
  logic               rem_ge;
  logic [19:0]        quo_lo;
  logic signed [18:0] accel_res [3];

  assign stat.action   = act_r;
  assign stat.cnt_zero = (cal_count_r == '0);
  assign stat.cal_full = (taken_r >= cal_count_r) && (taken_r != '0);
  assign stat.out_free = !out_valid_r || out_tready;

  // Gyro: (raw*16 - bias) * K; temperature: raw * 50251.
  assign gyro_x16 = {g_raw_r[cmd.sel][15], g_raw_r[cmd.sel], 4'b0000};
  assign bias_ext = {bias_r[cmd.sel][19], bias_r[cmd.sel]};
  assign mul_a    = (cmd.sel == igbs_pkg::MUL_TEMP) ?
                    {{5{temp_raw_r[15]}}, temp_raw_r} : (gyro_x16 - bias_ext);
  assign mul_b    = (cmd.sel == igbs_pkg::MUL_TEMP) ?
                    igbs_pkg::TEMP_SCALE : igbs_pkg::gyro_k(gyro_range_r);
  assign prod     = mul_a * mul_b;
  assign prod_sh  = prod_r >>> 16;

  // Restoring division of |sum|*16 by the sample count, one bit a cycle.
  assign sum_sel = sum_r[cmd.sel];
  assign mag     = sum_sel[32] ? 33'(-sum_sel) : sum_sel;
  assign rem_sh  = {rem_r, quo_r[igbs_pkg::DIV_W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, taken_r});
  assign quo_lo  = quo_r[19:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      accel_res[i] = 19'({{3{a_raw_r[i][15]}}, a_raw_r[i]} <<< accel_range_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_range_r <= igbs_pkg::ACCEL_RANGE_RST;
      gyro_range_r  <= igbs_pkg::GYRO_RANGE_RST;
      cal_count_r   <= igbs_pkg::CAL_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        igbs_pkg::CFG_ACCEL_RANGE: accel_range_r <= cfg_wdata[1:0];
        igbs_pkg::CFG_GYRO_RANGE:  gyro_range_r  <= cfg_wdata[1:0];
        igbs_pkg::CFG_CAL_COUNT:   cal_count_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Request payload and intermediate results.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r      <= in_tuser;
      a_raw_r[0] <= in_tdata[15:0];
      a_raw_r[1] <= in_tdata[31:16];
      a_raw_r[2] <= in_tdata[47:32];
      g_raw_r[0] <= in_tdata[63:48];
      g_raw_r[1] <= in_tdata[79:64];
      g_raw_r[2] <= in_tdata[95:80];
      temp_raw_r <= in_tdata[111:96];
    end
    if (cmd.mul) begin
      prod_r <= prod;
    end
    if (cmd.wb) begin
      if (cmd.sel == igbs_pkg::MUL_TEMP) begin
        temp_res_r <= prod_sh[15:0] + igbs_pkg::TEMP_OFFSET;
      end else begin
        gyro_res_r[cmd.sel] <= prod_sh[16:0];
      end
    end
    if (cmd.div_init) begin
      neg_r <= sum_sel[32];
      quo_r <= {mag[31:0], 4'b0000};
      rem_r <= '0;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[igbs_pkg::DIV_W-2:0], rem_ge};
      rem_r <= rem_ge ? 16'(rem_sh - {1'b0, taken_r}) : rem_sh[15:0];
    end
  end

  // Calibration state and status.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        sum_r[i]  <= '0;
        bias_r[i] <= '0;
      end
      taken_r      <= '0;
      calibrated_r <= 1'b0;
      status_r     <= igbs_pkg::ST_OK;
    end else begin
      if (cmd.load) begin
        status_r <= igbs_pkg::ST_OK;
      end
      if (cmd.err) begin
        status_r <= igbs_pkg::ST_ERR_ZERO;
      end
      if (cmd.accum) begin
        for (int i = 0; i < 3; i++) begin
          sum_r[i] <= sum_r[i] + {{17{g_raw_r[i][15]}}, g_raw_r[i]};
        end
        taken_r <= taken_r + 16'd1;
      end
      if (cmd.div_store) begin
        bias_r[cmd.sel] <= neg_r ? 20'(-quo_lo) : quo_lo;
      end
      if (cmd.abort || cmd.cal_done) begin
        for (int i = 0; i < 3; i++) begin
          sum_r[i] <= '0;
        end
        taken_r      <= '0;
        calibrated_r <= cmd.cal_done;
      end
      if (cmd.cal_done) begin
        status_r <= igbs_pkg::ST_CAL_DONE;
      end
    end
  end

  // Output register; a finished result waits here while the next request runs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (act_r == igbs_pkg::ACT_CONVERT) begin
        out_data_r <= {4'b0000, temp_res_r, gyro_res_r[2], gyro_res_r[1],
                       gyro_res_r[0], accel_res[2], accel_res[1], accel_res[0]};
      end else begin
        out_data_r <= '0;
      end
      out_user_r <= {status_r, calibrated_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_cal_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cal_done |=> calibrated_r && (taken_r == '0) &&
                     (status_r == igbs_pkg::ST_CAL_DONE))
    else $error("calibration completion did not update state");

  a_abort_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.abort |=> !calibrated_r && (taken_r == '0))
    else $error("abort did not clear calibration progress");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result loaded over an unclaimed result");

  a_err_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.err |-> (cal_count_r == '0))
    else $error("zero count error raised with nonzero count");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_init || cmd.div_step || cmd.div_store) |-> (taken_r != '0))
    else $error("bias division with zero divisor");

endmodule

[rtl/imu_gyro_bias_and_scale.sv]
// ----------------------------------------------------------------------
// IMU gyro bias and scale
// Converts raw IMU samples to physical units and averages gyro samples
// into stored bias offsets.
// ----------------------------------------------------------------------
// A conversion multiplies the three gyro axes and the temperature in turn
//   on the shared multiplier; a plain calibration sample only accumulates.
// The sample that closes a calibration runs three serial divisions, one
//   per axis (36 quotient bits plus setup and store).
// Requests are taken one at a time; the next is taken the cycle after a
//   result is loaded, even while that result still waits in the output.
// Reset (rst_n low, synchronous) clears sums, biases and calibration and
//   restores the configuration defaults.
module imu_gyro_bias_and_scale (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // accel_x_raw, accel_y_raw, accel_z_raw, gyro_x_raw, gyro_y_raw,
  // gyro_z_raw, temp_raw (16 bits each)
  input  logic [111:0] in_tdata,
  // action
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // accel_x_out, accel_y_out, accel_z_out (19 bits), gyro_x_out,
  // gyro_y_out, gyro_z_out (17 bits), temp_out (16 bits), zero fill
  output logic [127:0] out_tdata,
  // bias_valid, status
  output logic [2:0]   out_tuser,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [15:0]  cfg_wdata
);

  igbs_pkg::igbs_cmd_t  cmd;
  igbs_pkg::igbs_stat_t stat;

  igbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  igbs_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------
// Testbench for imu_gyro_bias_and_scale
// Streams raw IMU samples into the block. Every request is predicted in a
// small tracker class: unit conversion, gyro bias averaging, abort and
// the zero-count error. Each result is checked field by field against
// the oldest prediction. Both stream sides stall in random bursts until CALM_AFTER requests are sent.
// ----------------------------------------------------------------------
module tb_top;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int unsigned RUN_ITEMS = 1250;
  localparam int unsigned CALM_AFTER = 1080;
  localparam longint TEMP_GAIN = 50251;
  localparam longint TEMP_ZERO = 5376;

  // Raw sample as it sits in in_tdata, accel_x in the lowest bits.
  typedef struct packed {
    logic signed [15:0] temp_raw;
    logic signed [15:0] gyro_z;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_x;
    logic signed [15:0] accel_z;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_x;
  } sample_t;

  // Converted reading as {out_tuser, out_tdata}.
  typedef struct packed {
    logic [1:0]         status;
    logic               bias_valid;
    logic [3:0]         pad;
    logic signed [15:0] temp_out;
    logic signed [16:0] gyro_z;
    logic signed [16:0] gyro_y;
    logic signed [16:0] gyro_x;
    logic signed [18:0] accel_z;
    logic signed [18:0] accel_y;
    logic signed [18:0] accel_x;
  } reading_t;

  class imu_conversion_tracker;
    reading_t    due_readings[$];
    int unsigned mismatches;
    logic [1:0]  accel_range;
    logic [1:0]  gyro_range;
    logic [15:0] cal_count;
    longint      sum_x, sum_y, sum_z;
    int unsigned samples_taken;
    longint      bias_x, bias_y, bias_z;
    bit          calibrated;

    function new();
      mismatches = 0;
      accel_range = igbs_pkg::ACCEL_RANGE_RST;
      gyro_range = igbs_pkg::GYRO_RANGE_RST;
      cal_count = igbs_pkg::CAL_COUNT_RST;
      sum_x = 0;
      sum_y = 0;
      sum_z = 0;
      samples_taken = 0;
      bias_x = 0;
      bias_y = 0;
      bias_z = 0;
      calibrated = 1'b0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        igbs_pkg::CFG_ACCEL_RANGE: accel_range = val[1:0];
        igbs_pkg::CFG_GYRO_RANGE:  gyro_range = val[1:0];
        igbs_pkg::CFG_CAL_COUNT:   cal_count = val;
        default: ;
      endcase
    endfunction

    function longint rate_gain();
      case (gyro_range)
        2'd0:    return 500;
        2'd1:    return 1001;
        2'd2:    return 1998;
        default: return 3996;
      endcase
    endfunction

    // Arithmetic shift of a signed longint is a floor division.
    function logic signed [16:0] rate_out(longint raw, longint bias);
      longint p;
      p = (raw * 16 - bias) * rate_gain();
      return 17'(p >>> 16);
    endfunction

    function void absorb_sample(logic [1:0] action, sample_t s);
      reading_t r;
      longint   n;
      r = '0;
      r.status = igbs_pkg::ST_OK;
      case (action)
        igbs_pkg::ACT_CONVERT: begin
          r.accel_x = 19'(longint'(s.accel_x) <<< accel_range);
          r.accel_y = 19'(longint'(s.accel_y) <<< accel_range);
          r.accel_z = 19'(longint'(s.accel_z) <<< accel_range);
          r.gyro_x = rate_out(longint'(s.gyro_x), bias_x);
          r.gyro_y = rate_out(longint'(s.gyro_y), bias_y);
          r.gyro_z = rate_out(longint'(s.gyro_z), bias_z);
          r.temp_out = 16'(((longint'(s.temp_raw) * TEMP_GAIN) >>> 16) + TEMP_ZERO);
        end
        igbs_pkg::ACT_CAL: begin
          if (cal_count == 0) begin
            r.status = igbs_pkg::ST_ERR_ZERO;
          end else begin
            sum_x += longint'(s.gyro_x);
            sum_y += longint'(s.gyro_y);
            sum_z += longint'(s.gyro_z);
            samples_taken = (samples_taken + 1) & 16'hFFFF;
            // A count lowered mid-run closes at once; divide by what was taken.
            if (samples_taken >= cal_count && samples_taken != 0) begin
              n = longint'(samples_taken);
              bias_x = (sum_x * 16) / n;
              bias_y = (sum_y * 16) / n;
              bias_z = (sum_z * 16) / n;
              calibrated = 1'b1;
              sum_x = 0;
              sum_y = 0;
              sum_z = 0;
              samples_taken = 0;
              r.status = igbs_pkg::ST_CAL_DONE;
            end
          end
        end
        igbs_pkg::ACT_ABORT: begin
          sum_x = 0;
          sum_y = 0;
          sum_z = 0;
          samples_taken = 0;
          calibrated = 1'b0;
        end
        default: ;
      endcase
      r.bias_valid = calibrated;
      due_readings.push_back(r);
    endfunction

    function void check_field(string name, longint want, longint got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void compare_reading(logic [127:0] data, logic [2:0] user);
      reading_t got;
      reading_t want;
      got = {user, data};
      if (due_readings.size() == 0) begin
        $error("result arrived with no request outstanding");
        mismatches++;
        return;
      end
      want = due_readings.pop_front();
      check_field("accel_x_out", want.accel_x, got.accel_x);
      check_field("accel_y_out", want.accel_y, got.accel_y);
      check_field("accel_z_out", want.accel_z, got.accel_z);
      check_field("gyro_x_out", want.gyro_x, got.gyro_x);
      check_field("gyro_y_out", want.gyro_y, got.gyro_y);
      check_field("gyro_z_out", want.gyro_z, got.gyro_z);
      check_field("temp_out", want.temp_out, got.temp_out);
      check_field("zero_fill", want.pad, got.pad);
      check_field("bias_valid", want.bias_valid, got.bias_valid);
      check_field("status", want.status, got.status);
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [111:0] in_tdata = '0;
  logic [1:0]   in_tuser = igbs_pkg::ACT_CONVERT;
  logic         out_tvalid;
  logic         out_tready = 1'b1;
  logic [127:0] out_tdata;
  logic [2:0]   out_tuser;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_addr = igbs_pkg::CFG_ACCEL_RANGE;
  logic [15:0]  cfg_wdata = '0;

  imu_conversion_tracker tracker = new();
  int unsigned sent = 0;
  bit          calm = 1'b0;

  imu_gyro_bias_and_scale DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [15:0] rand_raw();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    s.accel_x = rand_raw();
    s.accel_y = rand_raw();
    s.accel_z = rand_raw();
    s.gyro_x = rand_raw();
    s.gyro_y = rand_raw();
    s.gyro_z = rand_raw();
    s.temp_raw = rand_raw();
    return s;
  endfunction

  function automatic sample_t flat_sample(logic [15:0] v);
    return {7{v}};
  endfunction

  // Leaves in_tvalid high after the request unless a gap follows.
  task automatic send_sample(input logic [1:0] action, input sample_t s);
    in_tvalid <= 1'b1;
    in_tuser <= action;
    in_tdata <= s;
    do @(posedge clk); while (!in_tready);
    tracker.absorb_sample(action, s);
    sent++;
    calm = (sent >= CALM_AFTER);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (tracker.due_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    tracker.set_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tracker.compare_reading(out_tdata, out_tuser);
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    sample_t     s;
    int unsigned pick;
    int unsigned count;
    int unsigned len;
    int unsigned cal_pct;
    bit          long_run;
    logic [1:0]  act;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Conversions at the reset ranges, uncalibrated, then the odd actions.
    send_sample(igbs_pkg::ACT_CONVERT, flat_sample(16'h8000));
    send_sample(igbs_pkg::ACT_CONVERT, flat_sample(16'h7FFF));
    send_sample(igbs_pkg::ACT_CONVERT, flat_sample(16'h0000));
    send_sample(igbs_pkg::ACT_CONVERT, flat_sample(16'hFFFF));
    send_sample(ACT_UNUSED, rand_sample());
    send_sample(igbs_pkg::ACT_ABORT, rand_sample());

    // A calibration sample with a zero count is refused.
    wait_idle();
    write_reg(igbs_pkg::CFG_CAL_COUNT, 16'd0);
    send_sample(igbs_pkg::ACT_CAL, rand_sample());

    // Short full calibration, then a conversion against the new bias.
    wait_idle();
    write_reg(igbs_pkg::CFG_CAL_COUNT, 16'd3);
    send_sample(igbs_pkg::ACT_CAL, flat_sample(16'h7FFF));
    send_sample(igbs_pkg::ACT_CAL, flat_sample(16'h7FFF));
    send_sample(igbs_pkg::ACT_CAL, flat_sample(16'h8000));
    send_sample(igbs_pkg::ACT_CONVERT, flat_sample(16'h8000));

    // Count lowered below the samples already taken closes the average.
    wait_idle();
    write_reg(igbs_pkg::CFG_CAL_COUNT, 16'hFFFF);
    send_sample(igbs_pkg::ACT_CAL, flat_sample(16'h8000));
    send_sample(igbs_pkg::ACT_CAL, flat_sample(16'h8000));
    wait_idle();
    write_reg(igbs_pkg::CFG_CAL_COUNT, 16'd1);
    send_sample(igbs_pkg::ACT_CAL, flat_sample(16'h8000));
    send_sample(igbs_pkg::ACT_CONVERT, flat_sample(16'h7FFF));
    // Abort drops the valid flag but the old bias still applies.
    send_sample(igbs_pkg::ACT_ABORT, rand_sample());
    send_sample(igbs_pkg::ACT_CONVERT, flat_sample(16'h7FFF));

    wait_idle();
    write_reg(igbs_pkg::CFG_ACCEL_RANGE, 16'd0);
    write_reg(igbs_pkg::CFG_GYRO_RANGE, 16'd0);
    send_sample(igbs_pkg::ACT_CONVERT, flat_sample(16'h8000));
    wait_idle();
    write_reg(igbs_pkg::CFG_ACCEL_RANGE, 16'd1);
    write_reg(igbs_pkg::CFG_GYRO_RANGE, 16'd1);
    send_sample(igbs_pkg::ACT_CONVERT, flat_sample(16'h7FFF));
    wait_idle();
    write_reg(igbs_pkg::CFG_ACCEL_RANGE, 16'd2);
    write_reg(igbs_pkg::CFG_GYRO_RANGE, 16'd2);
    send_sample(igbs_pkg::ACT_CONVERT, rand_sample());

    // Random phases: mostly calibration runs mixed with conversions. Sums
    // carry over between phases, so a smaller count can close a run early.
    while (sent < RUN_ITEMS) begin
      wait_idle();
      write_reg(igbs_pkg::CFG_ACCEL_RANGE, 16'($urandom_range(0, 3)));
      write_reg(igbs_pkg::CFG_GYRO_RANGE, 16'($urandom_range(0, 3)));
      pick = $urandom_range(0, 19);
      if (pick == 0)
        count = 0;
      else if (pick == 1)
        count = 16'hFFFF;
      else if (pick == 2)
        count = $urandom_range(100, 250);
      else
        count = $urandom_range(1, 10);
      write_reg(igbs_pkg::CFG_CAL_COUNT, 16'(count));
      long_run = (pick == 2);
      cal_pct = long_run ? 85 : 55;
      len = long_run ? count + count / 4 + 10 : $urandom_range(8, 40);
      repeat (len) begin
        if (sent >= RUN_ITEMS)
          break;
        pick = $urandom_range(0, 99);
        if (pick < cal_pct)
          act = igbs_pkg::ACT_CAL;
        else if (pick < 92 || long_run)
          act = igbs_pkg::ACT_CONVERT;
        else if (pick < 97)
          act = igbs_pkg::ACT_ABORT;
        else
          act = ACT_UNUSED;
        s = rand_sample();
        send_sample(act, s);
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    tracker.mismatches += tracker.due_readings.size();
    if (tracker.mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
